[hw/rtl/lpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the longest-prefix router
// Item payloads, the table entry layout, result codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Default number of stored routes.
  localparam int TABLE_DEPTH_DEF = 16;
  // Number of outgoing interfaces; larger interface numbers are clamped.
  localparam int NUM_PORTS = 4;
  // Longest meaningful prefix length.
  localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

  localparam logic [0:0] KIND_ADD   = 1'b0;
  localparam logic [0:0] KIND_ROUTE = 1'b1;

  typedef enum logic [2:0] {
    STS_FORWARDED   = 3'd0,
    STS_NO_ROUTE    = 3'd1,
    STS_TTL_EXPIRED = 3'd2,
    STS_ADDED       = 3'd3,
    STS_FULL        = 3'd4
  } lpr_status_t;

  typedef struct packed {
    logic [0:0]  kind;
    logic [31:0] new_prefix;
    logic [5:0]  new_prefix_len;
    logic [0:0]  new_has_hop;
    logic [31:0] new_hop_addr;
    logic [1:0]  new_port;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;
  } lpr_in_t;

  typedef struct packed {
    lpr_status_t status;
    logic [1:0]  out_port;
    logic [31:0] hop_addr_out;
    logic [7:0]  ttl_out;
  } lpr_out_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  prefix_len;
    logic        has_hop;
    logic [31:0] hop_addr;
    logic [1:0]  port;
  } lpr_entry_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DRAIN,
    CS_RESULT
  } lpr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // an item is accepted this cycle
    logic add_write;   // the accepted item is an add
    logic scan_issue;  // read the next table entry
    logic out_load;    // load the result register
  } lpr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_is_route; // kind of the item offered at the input
    logic count_zero;  // table holds no routes
    logic last_issue;  // the entry being read is the last stored one
    logic out_free;    // result register can take a new result
  } lpr_sts_t;

  // Network mask for a prefix length of 0 to 32 (longer lengths saturate).
  function automatic logic [31:0] mask_for(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= MAX_PREFIX_LEN) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/lpr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lpr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_ctrl: sequencing state machine of the router
// Accepts items, steps the table scan and hands results to the output stage.
// ----------------------------------------------------------------------------
module lpr_ctrl
  import lpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lpr_sts_t sts,
  output lpr_cmd_t      cmd
);

  lpr_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (accept) begin
          if (!sts.in_is_route || sts.count_zero) begin
            state_nxt = CS_RESULT;
          end else begin
            state_nxt = CS_SCAN;
          end
        end
      end
      CS_SCAN: begin
        if (sts.last_issue) begin
          state_nxt = CS_DRAIN;
        end
      end
      CS_DRAIN: state_nxt = CS_RESULT;
      CS_RESULT: begin
        if (sts.out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = accept;
        cmd.add_write = accept && !sts.in_is_route;
      end
      CS_SCAN:   cmd.scan_issue = 1'b1;
      CS_DRAIN:  cmd = '0;
      CS_RESULT: cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lpr_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_datapath: route table, masked comparator and result register
// Holds the table memory and route count, compares one entry per cycle
// against the destination and keeps the best match so far.
// ----------------------------------------------------------------------------
module lpr_datapath
  import lpr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lpr_in_t  in_data,
  input  wire lpr_cmd_t cmd,
  output lpr_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lpr_out_t      out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(lpr_entry_t);

  logic [CW-1:0] count_r;
  logic          full;
  logic [AW-1:0] idx_r;
  logic          cmp_vld_r;
  lpr_in_t       item_r;
  logic          add_full_r;

  logic          found_r;
  logic [5:0]    best_len_r;
  logic          best_has_hop_r;
  logic [31:0]   best_hop_r;
  logic [1:0]    best_port_r;

  lpr_entry_t    wr_entry;
  logic [EW-1:0] rd_word;
  lpr_entry_t    rd_entry;
  logic          hit;

  logic          out_valid_r;
  lpr_out_t      out_r, res_nxt;

  assign full = (count_r == CW'(TABLE_DEPTH));

  // Lengths above 32 and interfaces beyond the last are clamped on storage.
  always_comb begin
    wr_entry.prefix     = in_data.new_prefix;
    wr_entry.prefix_len = (in_data.new_prefix_len > MAX_PREFIX_LEN) ?
                          MAX_PREFIX_LEN : in_data.new_prefix_len;
    wr_entry.has_hop    = in_data.new_has_hop;
    wr_entry.hop_addr   = in_data.new_hop_addr;
    if (int'(in_data.new_port) >= NUM_PORTS) begin
      wr_entry.port = 2'(NUM_PORTS - 1);
    end else begin
      wr_entry.port = in_data.new_port;
    end
  end

  lpr_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.add_write && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_entry),
    .re    (cmd.scan_issue),
    .raddr (idx_r),
    .rdata (rd_word)
  );

  assign rd_entry = lpr_entry_t'(rd_word);

  // Equal lengths favour the later entry, hence the non-strict compare.
  assign hit = cmp_vld_r &&
               ((item_r.dest_addr & mask_for(rd_entry.prefix_len)) == rd_entry.prefix) &&
               (rd_entry.prefix_len >= best_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.add_write && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.capture) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          idx_r <= idx_r + AW'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r     <= in_data;
      add_full_r <= full;
      best_len_r <= '0;
    end else if (hit) begin
      best_len_r     <= rd_entry.prefix_len;
      best_has_hop_r <= rd_entry.has_hop;
      best_hop_r     <= rd_entry.hop_addr;
      best_port_r    <= rd_entry.port;
    end
  end

  always_comb begin
    res_nxt = '0;
    if (item_r.kind == KIND_ADD) begin
      res_nxt.status = add_full_r ? STS_FULL : STS_ADDED;
    end else if (!found_r) begin
      res_nxt.status = STS_NO_ROUTE;
    end else if (item_r.ttl_in <= 8'd1) begin
      res_nxt.status = STS_TTL_EXPIRED;
    end else begin
      res_nxt.status       = STS_FORWARDED;
      res_nxt.out_port     = best_port_r;
      res_nxt.hop_addr_out = best_has_hop_r ? best_hop_r : item_r.dest_addr;
      res_nxt.ttl_out      = item_r.ttl_in - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.in_is_route = (in_data.kind == KIND_ROUTE);
    sts.count_zero  = (count_r == '0);
    sts.last_issue  = (CW'(idx_r) == (count_r - CW'(1)));
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

[hw/rtl/ipv4_longest_prefix_router_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router_core: IPv4 longest-prefix-match routing table
// Stores routes appended by add items and forwards route items to the
// best-matching interface and next hop.
// ----------------------------------------------------------------------------
// Each input item either appends a route to the table or asks for the route
// of one datagram, and each item yields exactly one result item. Routes are
// held in a single table memory read through one port, so a lookup walks the
// stored routes one per cycle through a shared masked comparator. A route
// item passes from acceptance through the scan, a drain state for the last
// read and a result state before the next acceptance; when the table is
// empty no scan is needed and it goes straight to the result state, as an
// add item does. The longest matching prefix wins and on equal
// length the later route wins. A route whose prefix has bits set beyond its
// length never matches. When nothing matches the result is no route, which
// takes precedence over TTL expired (TTL of 0 or 1). An add to a full table
// stores nothing and reports table full. Results sit in an output register,
// so a finished result may wait for out_ready while the block takes the
// next item; the block stalls only when a second result is ready before the
// first has been taken. The table needs no clearing after reset: the route
// count is cleared and only entries below it are ever read.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router_core
  import lpr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire lpr_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output lpr_out_t     out_data
);

  lpr_cmd_t cmd;
  lpr_sts_t sts;

  // The controller owns the sequence; the datapath owns all storage.
  lpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
